### hdl/tpsv_pkg.sv
// Package: shared types, codes, constants and sine table for the three-phase sine PWM block.
`timescale 1ns / 1ps

package tpsv_pkg;

  localparam int FullScale = 65536;
  localparam int AmpW      = 17;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 17;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SPEED   = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FREQ_FLOOR = 3'd0,
    REG_FREQ_CEIL  = 3'd1,
    REG_BASE_RATE  = 3'd2,
    REG_GAIN       = 3'd3,
    REG_MIN_AMP    = 3'd4,
    REG_DEAD_LEAD  = 3'd5,
    REG_DEAD_GAP   = 3'd6,
    REG_MIN_PULSE  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL,
    ST_PAIR,
    ST_CLAMP,
    ST_AMP_MUL,
    ST_AMP_SET,
    ST_DIV_INIT,
    ST_DIV,
    ST_REVERSE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [6:0]      freq_floor;
    logic [6:0]      freq_ceil;
    logic [15:0]     base_rate;
    logic [15:0]     gain_q16;
    logic [AmpW-1:0] min_amp_q16;
    logic [7:0]      dead_lead;
    logic [7:0]      dead_gap;
    logic [7:0]      min_pulse;
  } cfg_t;

  typedef struct packed {
    logic   load_in;
    logic   tick;
    logic   clamp_f;
    logic   amp_mul;
    logic   amp_set;
    logic   div_init;
    logic   div_step;
    logic   phase_mul;
    logic   phase_pair;
    logic   advance;
    logic   swap;
    logic   load_out;
    phase_t phase;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_hit;
    logic f_zero;
    logic div_last;
  } dp_stat_t;

  function automatic logic [7:0] sine_lookup(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'd125;
      4'd1:    val = 8'd179;
      4'd2:    val = 8'd223;
      4'd3:    val = 8'd246;
      4'd4:    val = 8'd246;
      4'd5:    val = 8'd223;
      4'd6:    val = 8'd179;
      4'd7:    val = 8'd125;
      4'd8:    val = 8'd71;
      4'd9:    val = 8'd27;
      4'd10:   val = 8'd6;
      4'd11:   val = 8'd6;
      4'd12:   val = 8'd27;
      4'd13:   val = 8'd71;
      4'd14:   val = 8'd125;
      default: val = 8'd125;
    endcase
    return val;
  endfunction

endpackage

### hdl/tpsv_if.sv
// Interfaces: request, response and configuration channels with valid/ready handshake.
`timescale 1ns / 1ps

interface tpsv_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [9:0] pot_value;
  modport source (output valid, cmd, pot_value, input ready);
  modport sink (input valid, cmd, pot_value, output ready);
endinterface

interface tpsv_rsp_if;
  logic       valid;
  logic       ready;
  logic       updated;
  logic [7:0] phase_a_high;
  logic [7:0] phase_a_low;
  logic [7:0] phase_b_high;
  logic [7:0] phase_b_low;
  logic [7:0] phase_c_high;
  logic [7:0] phase_c_low;
  modport source (output valid, updated, phase_a_high, phase_a_low, phase_b_high,
                  phase_b_low, phase_c_high, phase_c_low, input ready);
  modport sink (input valid, updated, phase_a_high, phase_a_low, phase_b_high,
                phase_b_low, phase_c_high, phase_c_low, output ready);
endinterface

interface tpsv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/tpsv_cfg.sv
// Configuration register bank.
`timescale 1ns / 1ps

module tpsv_cfg (
  input  logic          clk,
  input  logic          rst,
  tpsv_cfg_if.sink      cfg,
  output tpsv_pkg::cfg_t regs
);
  import tpsv_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.freq_floor  <= 7'd20;
      regs.freq_ceil   <= 7'd120;
      regs.base_rate   <= 16'd1041;
      regs.gain_q16    <= 16'd475;
      regs.min_amp_q16 <= 17'd6554;
      regs.dead_lead   <= 8'd2;
      regs.dead_gap    <= 8'd5;
      regs.min_pulse   <= 8'd6;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_FREQ_FLOOR: regs.freq_floor  <= cfg.data[6:0];
        REG_FREQ_CEIL:  regs.freq_ceil   <= cfg.data[6:0];
        REG_BASE_RATE:  regs.base_rate   <= cfg.data[15:0];
        REG_GAIN:       regs.gain_q16    <= cfg.data[15:0];
        REG_MIN_AMP:    regs.min_amp_q16 <= cfg.data[AmpW-1:0];
        REG_DEAD_LEAD:  regs.dead_lead   <= cfg.data[7:0];
        REG_DEAD_GAP:   regs.dead_gap    <= cfg.data[7:0];
        REG_MIN_PULSE:  regs.min_pulse   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/tpsv_ctrl.sv
// Controller: sequences tick, speed sample and reverse transactions over the datapath.
`timescale 1ns / 1ps

module tpsv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [1:0]         req_cmd,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  tpsv_pkg::dp_stat_t stat,
  output tpsv_pkg::dp_cmd_t  dp
);
  import tpsv_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_A;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (dp.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (cmd_t'(req_cmd))
            CMD_TICK:    state_next = ST_TICK;
            CMD_SPEED:   state_next = ST_CLAMP;
            CMD_REVERSE: state_next = ST_REVERSE;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_TICK: begin
        phase_next = PH_A;
        state_next = stat.tick_hit ? ST_MUL : ST_FINISH;
      end
      ST_MUL:  state_next = ST_PAIR;
      ST_PAIR: begin
        case (phase)
          PH_A:    begin phase_next = PH_B; state_next = ST_MUL; end
          PH_B:    begin phase_next = PH_C; state_next = ST_MUL; end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_CLAMP:    state_next = ST_AMP_MUL;
      ST_AMP_MUL:  state_next = ST_AMP_SET;
      ST_AMP_SET:  state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = stat.f_zero ? ST_FINISH : ST_DIV;
      ST_DIV:      state_next = stat.div_last ? ST_FINISH : ST_DIV;
      ST_REVERSE:  state_next = ST_FINISH;
      ST_FINISH:   state_next = out_free ? ST_IDLE : ST_FINISH;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dp        = '0;
    dp.phase  = phase;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        dp.load_in = req_valid;
      end
      ST_TICK:     dp.tick = 1'b1;
      ST_MUL:      dp.phase_mul = 1'b1;
      ST_PAIR: begin
        dp.phase_pair = 1'b1;
        dp.advance    = (phase == PH_C);
      end
      ST_CLAMP:    dp.clamp_f = 1'b1;
      ST_AMP_MUL:  dp.amp_mul = 1'b1;
      ST_AMP_SET:  dp.amp_set = 1'b1;
      ST_DIV_INIT: dp.div_init = 1'b1;
      ST_DIV:      dp.div_step = 1'b1;
      ST_REVERSE:  dp.swap = 1'b1;
      ST_FINISH:   dp.load_out = out_free;
      default: ;
    endcase
  end

endmodule

### hdl/tpsv_dp.sv
// Datapath: tick counter, shared multiplier, serial divider, table pointers and compare registers.
`timescale 1ns / 1ps

module tpsv_dp (
  input  logic              clk,
  input  logic              rst,
  input  tpsv_pkg::cfg_t    cfg,
  input  tpsv_pkg::dp_cmd_t dp,
  output tpsv_pkg::dp_stat_t stat,
  input  logic [9:0]        pot_value,
  output logic              updated,
  output logic [7:0]        phase_a_high,
  output logic [7:0]        phase_a_low,
  output logic [7:0]        phase_b_high,
  output logic [7:0]        phase_b_low,
  output logic [7:0]        phase_c_high,
  output logic [7:0]        phase_c_low
);
  import tpsv_pkg::*;

  logic [7:0]      tick_count;
  logic [7:0]      tick_divider;
  logic [AmpW-1:0] amplitude;
  logic [3:0]      index_a, index_b, index_c;
  logic [7:0]      cmp [6];
  logic            upd;

  logic [9:0]      pot_q;
  logic [6:0]      freq;
  logic [32:0]     prod;
  logic [6:0]      rem;
  logic [15:0]     quo;
  logic [3:0]      div_cnt;

  logic [7:0]         tick_inc;
  logic               hit;
  logic [6:0]         f_raw;
  logic [AmpW-1:0]    mul_a;
  logic [15:0]        mul_b;
  logic [3:0]         ptr;
  logic [22:0]        amp_raw;
  logic [7:0]         trial;
  logic               ge;
  logic [7:0]         rem_n;
  logic [8:0]         level;
  logic signed [10:0] lvl_v;
  logic [7:0]         hi_val;
  logic [7:0]         lo_val;

  assign tick_inc = tick_count + 8'd1;
  assign hit      = tick_inc >= tick_divider;
  assign f_raw    = pot_q[9:3];

  always_comb begin
    case (dp.phase)
      PH_A:    ptr = index_a;
      PH_B:    ptr = index_b;
      default: ptr = index_c;
    endcase
  end

  always_comb begin
    if (dp.amp_mul) begin
      mul_a = {{(AmpW-7){1'b0}}, freq};
      mul_b = cfg.gain_q16;
    end else begin
      mul_a = amplitude;
      mul_b = {8'd0, sine_lookup(ptr)};
    end
  end

  assign amp_raw = prod[22:0];
  assign trial   = {rem, quo[15]};
  assign ge      = trial >= {1'b0, freq};
  assign rem_n   = ge ? (trial - {1'b0, freq}) : trial;

  assign level  = prod[24:16];
  assign lvl_v  = $signed({2'b00, level}) - $signed({3'b000, cfg.dead_lead});
  assign hi_val = (lvl_v < $signed({3'b000, cfg.min_pulse})) ? 8'd0 : lvl_v[7:0];
  assign lo_val = hi_val + cfg.dead_gap;

  assign stat.tick_hit = hit;
  assign stat.f_zero   = (freq == 7'd0);
  assign stat.div_last = (div_cnt == 4'd15);

  always_ff @(posedge clk) begin
    if (dp.load_in) begin
      pot_q <= pot_value;
    end
    if (dp.clamp_f) begin
      if (f_raw < cfg.freq_floor) begin
        freq <= cfg.freq_floor;
      end else if (f_raw > cfg.freq_ceil) begin
        freq <= cfg.freq_ceil;
      end else begin
        freq <= f_raw;
      end
    end
    if (dp.amp_mul || dp.phase_mul) begin
      prod <= mul_a * mul_b;
    end
    if (dp.div_init) begin
      rem     <= 7'd0;
      quo     <= cfg.base_rate;
      div_cnt <= 4'd0;
    end else if (dp.div_step) begin
      rem     <= rem_n[6:0];
      quo     <= {quo[14:0], ge};
      div_cnt <= div_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 8'd0;
      tick_divider <= 8'd0;
      amplitude    <= AmpW'(FullScale);
      index_a      <= 4'd0;
      index_b      <= 4'd5;
      index_c      <= 4'd10;
      upd          <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        cmp[i] <= 8'd0;
      end
    end else begin
      if (dp.load_in) begin
        upd <= 1'b0;
      end
      if (dp.tick) begin
        tick_count <= hit ? 8'd0 : tick_inc;
        if (hit) begin
          if (index_a == 4'd15) index_a <= 4'd0;
          if (index_b == 4'd15) index_b <= 4'd0;
          if (index_c == 4'd15) index_c <= 4'd0;
        end
      end else if (dp.advance) begin
        index_a <= index_a + 4'd1;
        index_b <= index_b + 4'd1;
        index_c <= index_c + 4'd1;
        upd     <= 1'b1;
      end else if (dp.swap) begin
        index_b <= index_c;
        index_c <= index_b;
      end
      if (dp.amp_set) begin
        if (amp_raw < {6'd0, cfg.min_amp_q16}) begin
          amplitude <= cfg.min_amp_q16;
        end else if (amp_raw > 23'(FullScale)) begin
          amplitude <= AmpW'(FullScale);
        end else begin
          amplitude <= amp_raw[AmpW-1:0];
        end
      end
      if (dp.div_init && (freq == 7'd0)) begin
        tick_divider <= 8'hFF;
      end else if (dp.div_step && (div_cnt == 4'd15)) begin
        tick_divider <= {quo[6:0], ge};
      end
      if (dp.phase_pair) begin
        case (dp.phase)
          PH_A: begin cmp[0] <= hi_val; cmp[1] <= lo_val; end
          PH_B: begin cmp[2] <= hi_val; cmp[3] <= lo_val; end
          default: begin cmp[4] <= hi_val; cmp[5] <= lo_val; end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp.load_out) begin
      updated      <= upd;
      phase_a_high <= cmp[0];
      phase_a_low  <= cmp[1];
      phase_b_high <= cmp[2];
      phase_b_low  <= cmp[3];
      phase_c_high <= cmp[4];
      phase_c_low  <= cmp[5];
    end
  end

endmodule

### hdl/three_phase_sine_pwm_vf_top.sv
// Top level: three-phase sine PWM compare generator with volts-per-hertz amplitude.
//
// One transaction at a time. Each request is taken in the idle cycle and gives exactly one
// response. An unused command, a reverse or a tick below the divider uses neither the
// multiplier nor the divider. A tick that recomputes the compares runs a multiply and a
// pair step per phase on one shared 17x16 multiplier, and a speed sample runs the 16-step
// bit-serial divider for the tick divider (skipped when the clamped frequency code is zero).
// The response sits in an output register, so the next request is accepted while the
// previous response waits for ready.
`timescale 1ns / 1ps

module three_phase_sine_pwm_vf_top (
  input logic       clk,
  input logic       rst,
  tpsv_req_if.sink  req,
  tpsv_rsp_if.source rsp,
  tpsv_cfg_if.sink  cfg
);
  import tpsv_pkg::*;

  cfg_t     regs;
  dp_cmd_t  dp;
  dp_stat_t stat;

  tpsv_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tpsv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .dp        (dp)
  );

  tpsv_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (regs),
    .dp           (dp),
    .stat         (stat),
    .pot_value    (req.pot_value),
    .updated      (rsp.updated),
    .phase_a_high (rsp.phase_a_high),
    .phase_a_low  (rsp.phase_a_low),
    .phase_b_high (rsp.phase_b_high),
    .phase_b_low  (rsp.phase_b_low),
    .phase_c_high (rsp.phase_c_high),
    .phase_c_low  (rsp.phase_c_low)
  );

endmodule
